@@ rtl/rase_pkg.sv @@
package rase_pkg;

   // Stack geometry
   localparam int DEPTH      = 1024;
   localparam int WORD_WIDTH = 64;
   localparam int IDX_W      = $clog2(DEPTH);

   // Beat field widths
   localparam int OP_W     = 4;
   localparam int ADDR_W   = 12;
   localparam int POS_W    = 13;
   localparam int FIELD_W  = 64;
   localparam int STATUS_W = 3;
   localparam int RIDX_W   = 10;
   localparam int CNT_W    = 11;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 4'd0,
      OP_POP     = 4'd1,
      OP_PEEK    = 4'd2,
      OP_POKE    = 4'd3,
      OP_EXTRACT = 4'd4,
      OP_INSERT  = 4'd5,
      OP_SHIFT   = 4'd6,
      OP_PREPEND = 4'd7,
      OP_ITEM    = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_ADDR   = 3'd1,
      ST_ITEM_RANGE = 3'd2,
      ST_UNDERFLOW  = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

endpackage

@@ rtl/rase_req_if.sv @@
interface rase_req_if;
   import rase_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [ADDR_W-1:0]       address;
   logic signed [POS_W-1:0] position;
   logic [FIELD_W-1:0]      word_in;

   modport source (output valid, op, address, position, word_in, input ready);
   modport sink   (input valid, op, address, position, word_in, output ready);
endinterface

@@ rtl/rase_rsp_if.sv @@
interface rase_rsp_if;
   import rase_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  read_value;
   logic [RIDX_W-1:0]   resolved_index;
   logic [CNT_W-1:0]    depth_now;

   modport source (output valid, status, read_value, resolved_index, depth_now, input ready);
   modport sink   (input valid, status, read_value, resolved_index, depth_now, output ready);
endinterface

@@ rtl/rase_ram.sv @@
module rase_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/rase_ctrl.sv @@
module rase_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   rase_req_if.sink                        req,
   rase_rsp_if.source                      rsp,
   output logic                            mem_we,
   output logic [rase_pkg::IDX_W-1:0]      mem_waddr,
   output logic [rase_pkg::WORD_WIDTH-1:0] mem_wdata,
   output logic [rase_pkg::IDX_W-1:0]      mem_raddr,
   input  logic [rase_pkg::WORD_WIDTH-1:0] mem_rdata
);
   import rase_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_GRAB,
      S_SLIDE_DN,
      S_SLIDE_UP,
      S_FINAL
   } state_type;

   state_type             state_ff;
   op_type                op_ff;
   logic [CNT_W-1:0]      top_ff;
   logic [IDX_W-1:0]      rd_addr_ff;   // address whose word sits on mem_rdata
   logic [IDX_W-1:0]      lo_ff;
   logic [WORD_WIDTH-1:0] val_ff;
   logic                  fin_we_ff;
   logic [IDX_W-1:0]      fin_addr_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [FIELD_W-1:0]    rsp_value_ff;
   logic [RIDX_W-1:0]     rsp_index_ff;
   logic [CNT_W-1:0]      rsp_depth_ff;

   logic                  out_free;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  addr_live;
   logic                  addr_in_mem;
   logic [IDX_W-1:0]      top_m1;
   logic [IDX_W-1:0]      addr_idx;
   logic [WORD_WIDTH-1:0] word;
   logic [POS_W:0]        pos_ext;
   logic [POS_W:0]        top_ext;
   logic [POS_W:0]        item_n;
   logic                  item_bad;
   logic                  more_dn;
   logic                  more_up;

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign req.ready   = (state_ff == S_IDLE) && out_free;
   assign accept      = req.valid && req.ready;

   assign full        = top_ff == CNT_W'(DEPTH);
   assign empty       = top_ff == '0;
   assign addr_live   = req.address < ADDR_W'(top_ff);
   assign addr_in_mem = req.address < ADDR_W'(DEPTH);
   assign top_m1      = IDX_W'(top_ff - CNT_W'(1));
   assign addr_idx    = req.address[IDX_W-1:0];
   assign word        = req.word_in[WORD_WIDTH-1:0];

   // item index: negative counts back from the top
   assign pos_ext  = {req.position[POS_W-1], req.position};
   assign top_ext  = (POS_W+1)'(top_ff);
   assign item_n   = pos_ext + (req.position[POS_W-1] ? top_ext : '0);
   assign item_bad = item_n[POS_W] || (item_n >= top_ext);

   // walk continuation
   assign more_dn = (CNT_W'(rd_addr_ff) + CNT_W'(1)) < top_ff;
   assign more_up = rd_addr_ff > lo_ff;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.read_value     = rsp_value_ff;
   assign rsp.resolved_index = rsp_index_ff;
   assign rsp.depth_now      = rsp_depth_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fin_addr_ff;
      mem_wdata = val_ff;
      mem_raddr = rd_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req.op)
                  OP_PUSH: begin
                     mem_we    = !full;
                     mem_waddr = IDX_W'(top_ff);
                     mem_wdata = word;
                  end
                  OP_POKE: begin
                     mem_we    = addr_in_mem;
                     mem_waddr = addr_idx;
                     mem_wdata = word;
                  end
                  OP_PREPEND: begin
                     mem_we    = !full && empty;
                     mem_waddr = '0;
                     mem_wdata = word;
                     mem_raddr = top_m1;
                  end
                  OP_POP, OP_INSERT: mem_raddr = top_m1;
                  OP_PEEK, OP_EXTRACT: mem_raddr = addr_idx;
                  OP_SHIFT: mem_raddr = '0;
                  default: mem_raddr = rd_addr_ff;
               endcase
            end
         end
         S_READ: mem_raddr = rd_addr_ff;
         S_GRAB: begin
            if (op_ff == OP_INSERT) begin
               mem_raddr = rd_addr_ff - IDX_W'(1);
            end else begin
               mem_raddr = rd_addr_ff + IDX_W'(1);
            end
         end
         S_SLIDE_DN: begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_ff - IDX_W'(1);
            mem_wdata = mem_rdata;
            mem_raddr = rd_addr_ff + IDX_W'(1);
         end
         S_SLIDE_UP: begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_ff + IDX_W'(1);
            mem_wdata = mem_rdata;
            mem_raddr = rd_addr_ff - IDX_W'(1);
         end
         S_FINAL: mem_we = fin_we_ff;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= mem_raddr;
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  // default beat: ok, current depth; overridden below
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_OK;
                  rsp_value_ff  <= '0;
                  rsp_index_ff  <= '0;
                  rsp_depth_ff  <= top_ff;
                  unique case (req.op)
                     OP_PUSH: begin
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           top_ff       <= top_ff + CNT_W'(1);
                           rsp_depth_ff <= top_ff + CNT_W'(1);
                        end
                     end
                     OP_POP: begin
                        if (empty) begin
                           rsp_status_ff <= ST_UNDERFLOW;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           top_ff       <= top_ff - CNT_W'(1);
                           state_ff     <= S_READ;
                        end
                     end
                     OP_PEEK: begin
                        if (!addr_live) begin
                           rsp_status_ff <= ST_BAD_ADDR;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_READ;
                        end
                     end
                     OP_POKE: begin
                        if (!addr_in_mem) begin
                           rsp_status_ff <= ST_BAD_ADDR;
                        end
                     end
                     OP_EXTRACT: begin
                        if (!addr_live) begin
                           rsp_status_ff <= ST_BAD_ADDR;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           op_ff        <= OP_EXTRACT;
                           state_ff     <= S_GRAB;
                        end
                     end
                     OP_INSERT: begin
                        if (!addr_live) begin
                           rsp_status_ff <= ST_BAD_ADDR;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           op_ff        <= OP_INSERT;
                           lo_ff        <= addr_idx;
                           state_ff     <= S_GRAB;
                        end
                     end
                     OP_SHIFT: begin
                        if (empty) begin
                           rsp_status_ff <= ST_UNDERFLOW;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           op_ff        <= OP_SHIFT;
                           state_ff     <= S_GRAB;
                        end
                     end
                     OP_PREPEND: begin
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                        end else if (empty) begin
                           top_ff       <= CNT_W'(1);
                           rsp_depth_ff <= CNT_W'(1);
                        end else begin
                           // walk every entry up one, then drop the word at the bottom
                           rsp_valid_ff <= 1'b0;
                           op_ff        <= OP_PREPEND;
                           val_ff       <= word;
                           lo_ff        <= '0;
                           fin_we_ff    <= 1'b1;
                           fin_addr_ff  <= '0;
                           state_ff     <= S_SLIDE_UP;
                        end
                     end
                     OP_ITEM: begin
                        if (item_bad) begin
                           rsp_status_ff <= ST_ITEM_RANGE;
                        end else begin
                           rsp_index_ff <= RIDX_W'(item_n);
                        end
                     end
                     default: rsp_status_ff <= ST_OK;
                  endcase
               end
            end
            S_READ: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_value_ff  <= FIELD_W'(mem_rdata);
               rsp_index_ff  <= '0;
               rsp_depth_ff  <= top_ff;
               state_ff      <= S_IDLE;
            end
            S_GRAB: begin
               val_ff <= mem_rdata;
               if (op_ff == OP_INSERT) begin
                  fin_we_ff   <= 1'b1;
                  fin_addr_ff <= lo_ff;
                  state_ff    <= more_up ? S_SLIDE_UP : S_FINAL;
               end else begin
                  fin_we_ff   <= op_ff == OP_EXTRACT;
                  fin_addr_ff <= top_m1;
                  state_ff    <= more_dn ? S_SLIDE_DN : S_FINAL;
               end
            end
            S_SLIDE_DN: begin
               if (!more_dn) begin
                  state_ff <= S_FINAL;
               end
            end
            S_SLIDE_UP: begin
               if (!more_up) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_value_ff  <= '0;
               rsp_index_ff  <= '0;
               rsp_depth_ff  <= top_ff;
               if (op_ff == OP_SHIFT) begin
                  rsp_value_ff <= FIELD_W'(val_ff);
                  top_ff       <= top_ff - CNT_W'(1);
                  rsp_depth_ff <= top_ff - CNT_W'(1);
               end else if (op_ff == OP_PREPEND) begin
                  top_ff       <= top_ff + CNT_W'(1);
                  rsp_depth_ff <= top_ff + CNT_W'(1);
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/random_access_stack_engine.sv @@
// Push, poke, item and every error case give their result beat in the cycle after the
// request beat; pop and peek first read the memory (S_READ). Extract, insert, shift and
// prepend move one entry per cycle through the single-port-pair stack RAM. Push, poke and
// item take one beat per cycle while rsp ready stays high; other ops block new beats till done.
// Reset (synchronous, active high) empties the stack and drops any pending result; the stack
// RAM is not cleared, and entries at or above the top never reach a result beat.
module random_access_stack_engine (
   input logic        clock,
   input logic        reset,
   rase_req_if.sink   req_bus,
   rase_rsp_if.source rsp_bus
);
   import rase_pkg::*;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [WORD_WIDTH-1:0] mem_rdata;

   // Sequencer: decodes each request beat, updates the depth, and walks the
   // RAM one entry per cycle for the rotate, shift and prepend operations.
   // A result beat waits in its own register; a new request beat is taken
   // only while that register is empty or its beat is claimed in the same cycle.
   rase_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Stack storage: one write and one registered read per cycle. Walks read
   // two entries ahead of the entry they write, so the two never collide.
   rase_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // A request is only taken when the result register can hold its beat.
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("request taken with result register occupied");

   a_depth_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.depth_now <= CNT_W'(DEPTH)))
      else $error("depth beyond capacity");

   a_index_live: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.resolved_index == '0
                         || CNT_W'(rsp_bus.resolved_index) < rsp_bus.depth_now))
      else $error("resolved index above top");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != ST_OK) |-> (rsp_bus.read_value == '0))
      else $error("error result carries a value");
endmodule

@@ test/stack_result_checker.sv @@
module stack_result_checker (
   input  logic clock,
   input  logic reset,
   input  logic check_done,
   rase_req_if  req_bus,
   rase_rsp_if  rsp_bus,
   output int   error_count,
   output int   pending,
   output int   model_depth
);
   import rase_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] read_value;
      logic [RIDX_W-1:0]  resolved_index;
      logic [CNT_W-1:0]   depth_now;
   } stack_result_type;

   // shadow copy of the stack
   logic [WORD_WIDTH-1:0] stack_image [DEPTH];
   int                    entry_count;
   stack_result_type      expected_results [$];

   int request_total;
   int result_total;
   int peak_depth;
   int status_hits [5];
   bit closed;

   task automatic report_mismatch(input string what);
      if (error_count < 50) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   task automatic predict_stack_op(input  logic [OP_W-1:0]        op,
                                   input  logic [ADDR_W-1:0]      addr,
                                   input  logic signed [POS_W-1:0] pos,
                                   input  logic [FIELD_W-1:0]     word,
                                   output stack_result_type       res);
      int                    a;
      int                    n;
      logic [WORD_WIDTH-1:0] v;
      a   = int'(addr);
      n   = int'(pos);
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (entry_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stack_image[entry_count] = word[WORD_WIDTH-1:0];
               entry_count++;
            end
         end
         OP_POP: begin
            if (entry_count == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               entry_count--;
               res.read_value = FIELD_W'(stack_image[entry_count]);
            end
         end
         OP_PEEK: begin
            if (a >= entry_count) res.status = ST_BAD_ADDR;
            else res.read_value = FIELD_W'(stack_image[a]);
         end
         OP_POKE: begin
            if (a >= DEPTH) res.status = ST_BAD_ADDR;
            else stack_image[a] = word[WORD_WIDTH-1:0];
         end
         OP_EXTRACT: begin
            // entry at addr rotates up to the top
            if (a >= entry_count) begin
               res.status = ST_BAD_ADDR;
            end else begin
               v = stack_image[a];
               for (int i = a; i + 1 < entry_count; i++) stack_image[i] = stack_image[i + 1];
               stack_image[entry_count - 1] = v;
            end
         end
         OP_INSERT: begin
            // top rotates down to addr
            if (a >= entry_count) begin
               res.status = ST_BAD_ADDR;
            end else begin
               v = stack_image[entry_count - 1];
               for (int i = entry_count - 1; i > a; i--) stack_image[i] = stack_image[i - 1];
               stack_image[a] = v;
            end
         end
         OP_SHIFT: begin
            if (entry_count == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.read_value = FIELD_W'(stack_image[0]);
               for (int i = 0; i + 1 < entry_count; i++) stack_image[i] = stack_image[i + 1];
               entry_count--;
            end
         end
         OP_PREPEND: begin
            if (entry_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = entry_count; i > 0; i--) stack_image[i] = stack_image[i - 1];
               stack_image[0] = word[WORD_WIDTH-1:0];
               entry_count++;
            end
         end
         OP_ITEM: begin
            if (n < 0) n += entry_count;
            if (n < 0 || n >= entry_count) res.status = ST_ITEM_RANGE;
            else res.resolved_index = RIDX_W'(n);
         end
         default: ;  // unused codes leave the stack alone
      endcase
      res.depth_now = CNT_W'(entry_count);
   endtask

   always @(posedge clock) begin
      stack_result_type exp_res;
      stack_result_type got_res;
      if (reset) begin
         expected_results.delete();
         entry_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_stack_op(req_bus.op, req_bus.address, req_bus.position, req_bus.word_in,
                             exp_res);
            expected_results.push_back(exp_res);
            request_total++;
            if (entry_count > peak_depth) peak_depth = entry_count;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_total++;
            got_res.status         = status_type'(rsp_bus.status);
            got_res.read_value     = rsp_bus.read_value;
            got_res.resolved_index = rsp_bus.resolved_index;
            got_res.depth_now      = rsp_bus.depth_now;
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               exp_res = expected_results.pop_front();
               status_hits[int'(exp_res.status)]++;
               if (got_res.status !== exp_res.status)
                  report_mismatch($sformatf("beat %0d status %0d, want %0d", result_total,
                                            got_res.status, exp_res.status));
               if (got_res.read_value !== exp_res.read_value)
                  report_mismatch($sformatf("beat %0d read_value %h, want %h", result_total,
                                            got_res.read_value, exp_res.read_value));
               if (got_res.resolved_index !== exp_res.resolved_index)
                  report_mismatch($sformatf("beat %0d resolved_index %0d, want %0d",
                                            result_total, got_res.resolved_index,
                                            exp_res.resolved_index));
               if (got_res.depth_now !== exp_res.depth_now)
                  report_mismatch($sformatf("beat %0d depth_now %0d, want %0d", result_total,
                                            got_res.depth_now, exp_res.depth_now));
            end
         end
      end
      model_depth = entry_count;
      pending     = expected_results.size();
      if (check_done && !closed) begin
         closed = 1'b1;
         if (pending != 0)
            report_mismatch($sformatf("%0d results never arrived", pending));
         $display("Summary: %0d request beats, %0d result beats, deepest stack %0d entries",
                  request_total, result_total, peak_depth);
         $display("Summary: ok %0d, bad address %0d, item range %0d, underflow %0d, full %0d",
                  status_hits[ST_OK], status_hits[ST_BAD_ADDR], status_hits[ST_ITEM_RANGE],
                  status_hits[ST_UNDERFLOW], status_hits[ST_FULL]);
      end
   end

endmodule

@@ test/testbench.sv @@
module testbench;
   import rase_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RANDOM_ITEMS = 520;
   // longest single op walks the whole stack, so let that much go by after the last beat
   localparam int TAIL_CYCLES  = DEPTH + 16;
   // ~1600 beats incl. the fill; worst beat ~ long sender gap + a full-stack walk + long
   // receiver stall. Several times that still sits far below this.
   localparam longint CYCLE_LIMIT = 4_000_000;

   // op codes the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd9;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

   localparam logic [FIELD_W-1:0] WORD_ONES = '1;
   localparam logic [FIELD_W-1:0] WORD_FIVE = 64'h5555_5555_5555_5555;
   localparam logic [FIELD_W-1:0] WORD_TEN  = 64'hAAAA_AAAA_AAAA_AAAA;

   logic   clock = 1'b0;
   logic   reset;
   logic   check_done;
   int     send_idle_pct;
   int     rsp_stall_pct;
   int     depth_ceiling;
   longint cycle_count;
   int     error_count;
   int     pending;
   int     model_depth;

   rase_req_if req_bus ();
   rase_rsp_if rsp_bus ();

   random_access_stack_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stack_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .check_done  (check_done),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .error_count (error_count),
      .pending     (pending),
      .model_depth (model_depth)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: ready drops at random per the current stall rate
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // One request beat. Called at a falling edge, returns at the falling edge after the
   // beat was taken, so valid is never dropped and raised within one step.
   task automatic send_req(input logic [OP_W-1:0]         op,
                           input logic [ADDR_W-1:0]       addr,
                           input logic signed [POS_W-1:0] pos,
                           input logic [FIELD_W-1:0]      word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.address  <= addr;
      req_bus.position <= pos;
      req_bus.word_in  <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random op, steered by the predicted depth so the stack hovers below depth_ceiling
   // and the walking ops stay cheap. Addresses and indexes mostly land around the live
   // range (both sides of the top), with some fully random values for the upper bits.
   task automatic issue_random_op();
      int                      r;
      int                      d;
      int                      n;
      logic [OP_W-1:0]         op;
      logic [ADDR_W-1:0]       addr;
      logic signed [POS_W-1:0] pos;
      logic [FIELD_W-1:0]      word;
      d = model_depth;
      r = $urandom_range(99);
      if (d > depth_ceiling && r < 45) begin
         op = (r < 30) ? OP_POP : OP_SHIFT;
      end else if (d < 2 && r < 35) begin
         op = (r < 20) ? OP_PUSH : OP_PREPEND;
      end else begin
         r = $urandom_range(99);
         if (r < 18)      op = OP_PUSH;
         else if (r < 32) op = OP_POP;
         else if (r < 44) op = OP_PEEK;
         else if (r < 53) op = OP_POKE;
         else if (r < 61) op = OP_EXTRACT;
         else if (r < 69) op = OP_INSERT;
         else if (r < 76) op = OP_SHIFT;
         else if (r < 83) op = OP_PREPEND;
         else if (r < 96) op = OP_ITEM;
         else op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end

      r = $urandom_range(99);
      if (r < 65)      addr = ADDR_W'($urandom_range(0, d));
      else if (r < 80) addr = ADDR_W'((d > 0) ? d - 1 : 0);
      else if (r < 90) addr = ADDR_W'($urandom_range(DEPTH - 4, DEPTH + 3));
      else             addr = ADDR_W'($urandom);

      r = $urandom_range(99);
      if (r < 40) begin
         pos = POS_W'($urandom_range(0, d + 1));
      end else if (r < 80) begin
         n   = $urandom_range(1, d + 2);
         pos = POS_W'(-n);
      end else begin
         pos = POS_W'($urandom);
      end

      r = $urandom_range(99);
      if (r < 5)       word = '0;
      else if (r < 10) word = WORD_ONES;
      else             word = {$urandom, $urandom};

      send_req(op, addr, pos, word);
   endtask

   // Fill to capacity, then hit the full-stack corners and the longest walks.
   task automatic fill_to_capacity();
      int saved_idle;
      int saved_stall;
      int saved_ceiling;
      saved_idle    = send_idle_pct;
      saved_stall   = rsp_stall_pct;
      saved_ceiling = depth_ceiling;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      depth_ceiling = DEPTH;
      while (model_depth < DEPTH) send_req(OP_PUSH, '0, '0, {$urandom, $urandom});
      send_req(OP_PUSH,    '0, '0, WORD_FIVE);          // full
      send_req(OP_PREPEND, '0, '0, WORD_TEN);           // full
      send_req(OP_POKE,    ADDR_W'(DEPTH - 1), '0, WORD_ONES);
      send_req(OP_PEEK,    ADDR_W'(DEPTH - 1), '0, '0);
      send_req(OP_PEEK,    '0, '0, '0);
      send_req(OP_ITEM,    '0, POS_W'(-DEPTH), '0);    // bottom via negative index
      send_req(OP_ITEM,    '0, POS_W'(DEPTH - 1), '0);
      send_req(OP_ITEM,    '0, POS_W'(-DEPTH - 1), '0);
      send_req(OP_ITEM,    '0, POS_W'(DEPTH), '0);
      send_req(OP_EXTRACT, '0, '0, '0);                 // longest rotate up
      send_req(OP_INSERT,  '0, '0, '0);                 // longest rotate down
      send_req(OP_EXTRACT, ADDR_W'(DEPTH - 1), '0, '0);
      send_req(OP_INSERT,  ADDR_W'(DEPTH - 1), '0, '0);
      send_req(OP_SHIFT,   '0, '0, '0);
      send_req(OP_PREPEND, '0, '0, WORD_TEN);
      repeat (12) issue_random_op();
      send_idle_pct = saved_idle;
      rsp_stall_pct = saved_stall;
      depth_ceiling = saved_ceiling;
   endtask

   initial begin
      reset            = 1'b1;
      check_done       = 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      depth_ceiling    = 8;
      req_bus.valid    = 1'b0;
      req_bus.op       = '0;
      req_bus.address  = '0;
      req_bus.position = '0;
      req_bus.word_in  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-stack errors first, then a small stack of edge words
      send_req(OP_POP,     '0, '0, '0);                 // underflow
      send_req(OP_SHIFT,   '0, '0, '0);                 // underflow
      send_req(OP_PEEK,    '0, '0, '0);                 // nothing live
      send_req(OP_EXTRACT, '0, '0, '0);
      send_req(OP_INSERT,  '0, '0, '0);                 // insert on empty
      send_req(OP_ITEM,    '0, '0, '0);
      send_req(OP_ITEM,    '0, POS_W'(-1), '0);
      send_req(OP_UNUSED_LAST, '1, '1, WORD_ONES);      // ignored code
      send_req(OP_POKE,    ADDR_W'(DEPTH - 1), '0, WORD_ONES);  // above the top is legal
      send_req(OP_POKE,    '1, '0, WORD_FIVE);          // beyond capacity
      send_req(OP_PUSH,    '0, '0, '0);
      send_req(OP_PUSH,    '0, '0, WORD_ONES);
      send_req(OP_PUSH,    '0, '0, WORD_FIVE);
      send_req(OP_PREPEND, '0, '0, WORD_TEN);
      send_req(OP_ITEM,    '0, POS_W'(-1), '0);
      send_req(OP_ITEM,    '0, POS_W'(-4), '0);
      send_req(OP_ITEM,    '0, POS_W'(-4096), '0);     // most negative index
      send_req(OP_ITEM,    '0, POS_W'(4095), '0);      // most positive index
      send_req(OP_PEEK,    ADDR_W'(3), '0, '0);
      send_req(OP_PEEK,    ADDR_W'(4), '0, '0);         // at the top: bad address
      send_req(OP_EXTRACT, '0, '0, '0);
      send_req(OP_INSERT,  ADDR_W'(3), '0, '0);         // insert at top: no change
      send_req(OP_INSERT,  '0, '0, '0);
      send_req(OP_EXTRACT, ADDR_W'(3), '0, '0);         // extract of top: no change
      send_req(OP_POP,     '0, '0, '0);
      send_req(OP_SHIFT,   '0, '0, '0);
      send_req(OP_UNUSED_FIRST, '0, '0, '0);

      // random: four handshake-pressure phases, full-stack excursion at the end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 8;
               rsp_stall_pct = 8;
            end
         endcase
         for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
            // new depth window every 50 beats
            if (k % 50 == 0) begin
               case ($urandom_range(3))
                  0:       depth_ceiling = 2;
                  1:       depth_ceiling = 6;
                  2:       depth_ceiling = 16;
                  default: depth_ceiling = 40;
               endcase
            end
            issue_random_op();
         end
      end
      fill_to_capacity();
      req_bus.valid <= 1'b0;

      // drain, then give the block room to show any stray beat
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      check_done <= 1'b1;
      @(posedge clock);
      @(negedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
